>>> rtl/rlum_pkg.sv
// Shared constants and types for the radial lens undistort map block.
// Used by the top level, the square-root pipeline and the divider pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rlum_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int MAX_DIM     = 4096;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  // Squared radius in pixels Q.4 squared, fits 34 bits for the field widths.
  localparam int SQ_W        = 34;
  // Square root input is the squared radius shifted by 8 bits.
  localparam int SQ_OUT_W    = 21;
  localparam int SQ_IN_W     = 2 * SQ_OUT_W;
  localparam int SQ_REM_W    = SQ_OUT_W + 2;

  // Table position divider: quotient is the Q.16 table position.
  localparam int DIV_D_W     = SQ_OUT_W;
  localparam int DIV_Q_W     = TBL_AW + 16;
  localparam int DIV_N_W     = DIV_D_W + DIV_Q_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_TABLE_LEN
  } cfg_reg_t;

endpackage

>>> rtl/radial_lut_lens_undistort_map.sv
// Top level of the radial lens undistort map engine.
// Depends on rlum_pkg, rlum_isqrt and rlum_div.
//
// Usage:
//  The slave stream carries items: tuser = 0 maps a destination pixel to its
//  source pixel, tuser = 1 writes one magnification table entry and gives no
//  result. The master stream carries one mapped result per map item, in order.
//  The configuration channel writes image size, distortion center and table
//  length; it is always ready, and the user must write it only while the block
//  is idle, which the block itself does not enforce. Throughput is one item per
//  clock while the receiver is ready. Each map item passes through the front
//  stages, the 21-stage square root pipeline, the 24-stage table position
//  divider and the interpolation and scaling stages. The maximum radius is
//  derived from the configuration by a free-running copy of the square root pipeline.
//  A table write takes effect at the table read stage, so every later item
//  sees it and every earlier one does not.
//  Reset clears all valid bits and restores the configuration defaults; the
//  table contents are undefined until written.
//  When the receiver stalls, the whole pipeline holds and s_tready drops;
//  nothing is lost or repeated.
`timescale 1ns / 1ps

module radial_lut_lens_undistort_map (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: dest_x[11:0], dest_y[23:12], table_index[31:24],
  // table_value[49:32], zero fill[55:50]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [55:0]                     s_tdata,
  // s_tuser: kind[0]
  input  logic                            s_tuser,
  // m_tdata: src_x[13:0], src_y[27:14], in_bounds[28],
  // src_pixel_index[52:29], dest_pixel_index[76:53], zero fill[79:77]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [79:0]                     m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rlum_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlum_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlum_pkg::*;

  typedef struct packed {
    logic        v;
    logic        kind;
    logic [7:0]  idx;
    logic [17:0] val;
    logic [16:0] dx;
    logic [16:0] dy;
    logic        lt;
    logic [23:0] didx;
  } side_t;

  logic en;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  logic [12:0] cfg_w, cfg_h;
  logic [15:0] cfg_cx, cfg_cy;
  logic [8:0]  cfg_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w   <= 13'd4096;
      cfg_h   <= 13'd4096;
      cfg_cx  <= 16'h8000;
      cfg_cy  <= 16'h8000;
      cfg_len <= 9'd1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg_w   <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT: cfg_h   <= cfg_data[12:0];
        CFG_CENTER_X:     cfg_cx  <= cfg_data;
        CFG_CENTER_Y:     cfg_cy  <= cfg_data;
        CFG_TABLE_LEN:    cfg_len <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Values derived from the configuration, recomputed every cycle.
  function automatic logic [16:0] half_span(input logic [12:0] dim, input logic [15:0] c);
    logic [16:0] full;
    full = {dim, 4'b0};
    if ({1'b0, full} > {1'b0, c, 1'b0}) return full - {1'b0, c};
    return {1'b0, c};
  endfunction

  logic [12:0]         w_c, h_c;
  logic [TBL_AW-1:0]   len_m1;
  logic [16:0]         rmx, rmy;
  logic [33:0]         rmx2, rmy2;
  logic [SQ_W-1:0]     sq_max;
  logic [SQ_OUT_W-1:0] rmax;
  logic [12:0]         w_sat, h_sat;
  logic [TBL_AW-1:0]   len_sat;

  always_comb begin
    w_sat = (cfg_w > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg_w;
    h_sat = (cfg_h > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg_h;
    if (cfg_len == '0) begin
      len_sat = '0;
    end else if (32'(cfg_len) > TABLE_DEPTH) begin
      len_sat = TBL_AW'(TABLE_DEPTH - 1);
    end else begin
      len_sat = TBL_AW'(cfg_len - 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    w_c    <= w_sat;
    h_c    <= h_sat;
    len_m1 <= len_sat;
    rmx    <= half_span(w_sat, cfg_cx);
    rmy    <= half_span(h_sat, cfg_cy);
    rmx2   <= rmx * rmx;
    rmy2   <= rmy * rmy;
    sq_max <= SQ_W'(rmx2 + rmy2);
  end

  rlum_isqrt u_rmax_sqrt (
    .clk      (clk),
    .en       (1'b1),
    .radicand ({sq_max, 8'b0}),
    .root     (rmax)
  );

  // Front stages: offsets, squares, squared radius, destination index.
  logic        v0, kind0;
  logic [11:0] px0, py0, px1, py1, py2;
  logic [7:0]  idx0;
  logic [17:0] val0;
  side_t       s1, s2, s3, s3_next;
  logic signed [33:0] dxx, dyy;
  logic [32:0] dxx2, dyy2;
  logic [24:0] dprod2;
  logic [SQ_W-1:0] sq3;
  side_t       sq_side_in;

  assign dxx = $signed(s1.dx) * $signed(s1.dx);
  assign dyy = $signed(s1.dy) * $signed(s1.dy);

  always_comb begin
    s3_next      = s2;
    s3_next.didx = 24'(dprod2 + 25'(py2));
  end

  always_comb begin
    sq_side_in    = s3;
    sq_side_in.lt = sq3 < sq_max;
  end

  // Square root of the point radius, with its sideband.
  logic [SQ_OUT_W-1:0] r_pt;
  side_t               sd_sq [SQ_OUT_W];

  rlum_isqrt u_pt_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand ({sq3, 8'b0}),
    .root     (r_pt)
  );

  // Table position: r * (len - 1) * 65536 / rmax.
  side_t                      sd_p;
  logic [SQ_OUT_W+TBL_AW-1:0] prod_p;
  logic [DIV_Q_W-1:0]         pos;
  side_t                      sd_dv [DIV_Q_W];

  rlum_div u_pos_div (
    .clk      (clk),
    .en       (en),
    .dividend ({prod_p, 16'b0}),
    .divisor  (rmax),
    .quotient (pos)
  );

  // Back stages: table addresses, read, interpolation, scaling, bounds.
  side_t             tsd [8];
  logic [TBL_AW-1:0] lo_raw, lo_c, hi_c, lo_a, hi_a;
  logic [TBL_AW:0]   hi_w;
  logic [15:0]       f_raw, f0, f1;

  always_comb begin
    lo_raw = pos[DIV_Q_W-1:16];
    f_raw  = pos[15:0];
    // Beyond the maximum radius the last entry is used unweighted.
    if (!sd_dv[DIV_Q_W-1].lt) begin
      lo_raw = len_m1;
      f_raw  = '0;
    end
    lo_c = (lo_raw > len_m1) ? len_m1 : lo_raw;
    hi_w = {1'b0, lo_raw} + ((f_raw != '0) ? (TBL_AW+1)'(1) : '0);
    hi_c = (hi_w > {1'b0, len_m1}) ? len_m1 : TBL_AW'(hi_w);
  end

  logic signed [17:0] mag_mem [TABLE_DEPTH];
  logic signed [17:0] rd_lo, rd_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      if (tsd[0].v && tsd[0].kind && (32'(tsd[0].idx) < TABLE_DEPTH)) begin
        mag_mem[TBL_AW'(tsd[0].idx)] <= tsd[0].val;
      end
      rd_lo <= mag_mem[lo_a];
      rd_hi <= mag_mem[hi_a];
    end
  end

  logic signed [35:0] p_lo, p_hi;
  logic signed [36:0] acc, rnd;
  logic signed [17:0] mag;
  logic signed [18:0] gain3;
  logic signed [35:0] mx, my;
  logic signed [37:0] nx, ny;
  logic signed [17:0] sx6, sy6;
  logic               inb7;
  logic [13:0]        satx7, saty7;
  logic [25:0]        sidxp7;
  logic [12:0]        sy7;
  logic               inb6;

  assign acc = 37'(p_lo) + 37'(p_hi);
  assign rnd = acc + 37'sd32768;
  assign mag = 18'(rnd >>> 16);

  assign inb6 = !sx6[17] && (sx6[16:0] < {4'b0, w_c}) &&
                !sy6[17] && (sy6[16:0] < {4'b0, h_c});

  function automatic logic [13:0] sat14(input logic signed [17:0] v);
    if (v > 18'sd8191) return 14'h1FFF;
    if (v < -18'sd8192) return 14'h2000;
    return v[13:0];
  endfunction

  function automatic logic signed [17:0] trunc20(input logic signed [37:0] v);
    logic signed [37:0] t;
    t = v + (v[37] ? 38'sd1048575 : 38'sd0);
    return 18'(t >>> 20);
  endfunction

  logic [13:0] o_sx, o_sy;
  logic        o_inb;
  logic [23:0] o_sidx, o_didx;

  // Valid bits and sideband.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      s1.v <= 1'b0;
      s2.v <= 1'b0;
      s3.v <= 1'b0;
      for (int i = 0; i < SQ_OUT_W; i++) sd_sq[i].v <= 1'b0;
      sd_p.v <= 1'b0;
      for (int i = 0; i < DIV_Q_W; i++) sd_dv[i].v <= 1'b0;
      for (int i = 0; i < 8; i++) tsd[i].v <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v0       <= s_tvalid;
      s1.v     <= v0;
      s1.kind  <= kind0;
      s1.idx   <= idx0;
      s1.val   <= val0;
      s1.dx    <= 17'({1'b0, px0, 4'b0} - {1'b0, cfg_cx});
      s1.dy    <= 17'({1'b0, py0, 4'b0} - {1'b0, cfg_cy});
      s1.lt    <= 1'b0;
      s1.didx  <= '0;
      s2       <= s1;
      s3       <= s3_next;
      sd_sq[0] <= sq_side_in;
      for (int i = 1; i < SQ_OUT_W; i++) sd_sq[i] <= sd_sq[i-1];
      sd_p     <= sd_sq[SQ_OUT_W-1];
      sd_dv[0] <= sd_p;
      for (int i = 1; i < DIV_Q_W; i++) sd_dv[i] <= sd_dv[i-1];
      tsd[0]   <= sd_dv[DIV_Q_W-1];
      for (int i = 1; i < 8; i++) tsd[i] <= tsd[i-1];
      m_tvalid <= tsd[7].v && !tsd[7].kind;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      kind0  <= s_tuser;
      px0    <= s_tdata[11:0];
      py0    <= s_tdata[23:12];
      idx0   <= s_tdata[31:24];
      val0   <= s_tdata[49:32];
      px1    <= px0;
      py1    <= py0;
      dxx2   <= 33'(dxx);
      dyy2   <= 33'(dyy);
      dprod2 <= px1 * h_c;
      py2    <= py1;
      sq3    <= SQ_W'(dxx2 + dyy2);
      prod_p <= r_pt * len_m1;
      lo_a   <= lo_c;
      hi_a   <= hi_c;
      f0     <= f_raw;
      f1     <= f0;
      p_lo   <= rd_lo * $signed({1'b0, 17'(17'h10000 - {1'b0, f1})});
      p_hi   <= rd_hi * $signed({2'b0, f1});
      gain3  <= 19'sd65536 + 19'(mag);
      mx     <= $signed(tsd[3].dx) * gain3;
      my     <= $signed(tsd[3].dy) * gain3;
      nx     <= $signed({6'b0, cfg_cx, 16'b0}) + 38'(mx);
      ny     <= $signed({6'b0, cfg_cy, 16'b0}) + 38'(my);
      sx6    <= trunc20(nx);
      sy6    <= trunc20(ny);
      inb7   <= inb6;
      satx7  <= sat14(sx6);
      saty7  <= sat14(sy6);
      sidxp7 <= sx6[12:0] * h_c;
      sy7    <= sy6[12:0];
      o_sx   <= satx7;
      o_sy   <= saty7;
      o_inb  <= inb7;
      o_sidx <= inb7 ? 24'(sidxp7 + 26'(sy7)) : '0;
      o_didx <= tsd[7].didx;
    end
  end

  assign m_tdata = {3'b0, o_didx, o_sidx, o_inb, o_sy, o_sx};

  // The interpolation addresses never leave the part of the table in use.
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    tsd[0].v && !tsd[0].kind |-> (lo_a <= len_m1) && (hi_a <= len_m1))
    else $error("table address beyond table length");

  // The upper entry is the lower one or its neighbor.
  a_addr_adjacent: assert property (@(posedge clk) disable iff (rst)
    tsd[0].v && !tsd[0].kind |->
      (hi_a == lo_a) || ({1'b0, hi_a} == {1'b0, lo_a} + (TBL_AW+1)'(1)))
    else $error("interpolation entries not adjacent");

  // An out-of-bounds result carries a zero source index.
  a_oob_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[28] |-> m_tdata[52:29] == 24'd0)
    else $error("source index set for out-of-bounds result");

  // An in-bounds result has non-negative source coordinates.
  a_inb_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> !m_tdata[13] && !m_tdata[27])
    else $error("negative source coordinate marked in bounds");

endmodule

>>> rtl/rlum_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on rlum_pkg for its widths.
`timescale 1ns / 1ps

module rlum_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rlum_pkg::SQ_IN_W-1:0]  radicand,
  output logic [rlum_pkg::SQ_OUT_W-1:0] root
);
  import rlum_pkg::*;

  typedef struct packed {
    logic [SQ_IN_W-1:0]  rad;
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_OUT_W-1:0] root;
  } sq_stage_t;

  sq_stage_t st [SQ_OUT_W];
  sq_stage_t st_in;

  // One digit of the classic pairwise square root recurrence.
  function automatic sq_stage_t sq_step(input sq_stage_t s);
    logic [SQ_REM_W+1:0] cur;
    logic [SQ_REM_W+1:0] trial;
    sq_stage_t           n;
    cur   = {s.rem, s.rad[SQ_IN_W-1 -: 2]};
    trial = (SQ_REM_W+2)'({s.root, 2'b01});
    n.rad = s.rad << 2;
    if (cur >= trial) begin
      n.rem  = SQ_REM_W'(cur - trial);
      n.root = {s.root[SQ_OUT_W-2:0], 1'b1};
    end else begin
      n.rem  = SQ_REM_W'(cur);
      n.root = {s.root[SQ_OUT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  assign st_in = '{rad: radicand, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sq_step(st_in);
      for (int i = 1; i < SQ_OUT_W; i++) begin
        st[i] <= sq_step(st[i-1]);
      end
    end
  end

  assign root = st[SQ_OUT_W-1].root;

endmodule

>>> rtl/rlum_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The caller guarantees the quotient fits DIV_Q_W bits. Depends on rlum_pkg.
`timescale 1ns / 1ps

module rlum_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rlum_pkg::DIV_N_W-1:0] dividend,
  input  logic [rlum_pkg::DIV_D_W-1:0] divisor,
  output logic [rlum_pkg::DIV_Q_W-1:0] quotient
);
  import rlum_pkg::*;

  typedef struct packed {
    logic [DIV_D_W-1:0] rem;
    logic [DIV_Q_W-1:0] num;
    logic [DIV_D_W-1:0] d;
    logic [DIV_Q_W-1:0] q;
  } dv_stage_t;

  dv_stage_t st [DIV_Q_W];
  dv_stage_t st_in;

  function automatic dv_stage_t dv_step(input dv_stage_t s);
    logic [DIV_D_W:0] cur;
    dv_stage_t        n;
    cur   = {s.rem, s.num[DIV_Q_W-1]};
    n.num = s.num << 1;
    n.d   = s.d;
    if (cur >= {1'b0, s.d}) begin
      n.rem = DIV_D_W'(cur - {1'b0, s.d});
      n.q   = {s.q[DIV_Q_W-2:0], 1'b1};
    end else begin
      n.rem = DIV_D_W'(cur);
      n.q   = {s.q[DIV_Q_W-2:0], 1'b0};
    end
    return n;
  endfunction

  assign st_in = '{rem: dividend[DIV_N_W-1 -: DIV_D_W], num: dividend[DIV_Q_W-1:0],
                   d: divisor, q: '0};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= dv_step(st_in);
      for (int i = 1; i < DIV_Q_W; i++) begin
        st[i] <= dv_step(st[i-1]);
      end
    end
  end

  assign quotient = st[DIV_Q_W-1].q;

endmodule
